FILE: rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial vector, request types and round helpers.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
        logic       message_empty;
    } t_in_req;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } t_out_req;

    // Classified request from front to back end
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } t_state;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [6:0] NUM_ROUNDS  = 7'd64;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

endpackage

FILE: rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic stream interface carrying one request of type T.
// ----------------------------------------------------------------------------
interface sha256_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input requests, drops no-op items, queues commands (2 deep).
// ----------------------------------------------------------------------------
module sha256_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sha256_if.sink                s_in,
    output logic                  o_cmd_valid,
    output sha256_pkg::t_cmd      o_cmd,
    input  logic                  i_cmd_pop
);
    sha256_pkg::t_cmd r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, keep;
    sha256_pkg::t_cmd cmd;

    assign s_in.ready = (r_cnt != 2'd2);
    // empty marker without last does nothing
    assign keep = !(s_in.data.message_empty && !s_in.data.is_last);
    assign push = s_in.valid && s_in.ready && keep;
    assign cmd.data_byte = s_in.data.data_byte;
    assign cmd.has_byte  = !s_in.data.message_empty;
    assign cmd.is_last   = s_in.data.is_last;

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_cmd_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !s_in.ready) else $error("ready while full");
`endif
endmodule

FILE: rtl/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 back end
// Packs bytes, runs one round per cycle, pads and emits the digest.
// ----------------------------------------------------------------------------
module sha256_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  sha256_pkg::t_cmd      i_cmd,
    output logic                  o_cmd_pop,
    sha256_if.source              m_out
);
    sha256_pkg::t_state r_st, n_st;
    logic [31:0] r_blk [16];
    logic [31:0] r_w   [16];
    logic [31:0] r_h   [8];
    logic [31:0] r_v   [8];
    logic [63:0] r_cnt;
    logic [6:0]  r_rnd;
    logic        r_fin;     // compression is part of finishing
    logic        r_two;     // length block still needed
    logic [1:0]  r_part;
    logic        r_ovalid;

    // last command stays captured while working
    logic r_lastcmd;
    logic ld_fin;  // pad stage loads block

    logic [5:0]  pos;
    logic [3:0]  wi;
    logic [31:0] wcur, s0, s1, wnew, t1, t2;
    logic [4:0]  bsh;

    assign pos = r_cnt[5:0];
    assign wi  = pos[5:2];
    assign bsh = {~pos[1:0], 3'b000};

    // schedule window as shift register: rounds 0..15 rotate the block words,
    // later rounds hold W[r-16..r-1] and compute W[r]
    assign s0   = sha256_pkg::ror(r_w[1], 7) ^ sha256_pkg::ror(r_w[1], 18) ^ (r_w[1] >> 3);
    assign s1   = sha256_pkg::ror(r_w[14], 17) ^ sha256_pkg::ror(r_w[14], 19)
                ^ (r_w[14] >> 10);
    assign wnew = r_w[0] + s0 + r_w[9] + s1;
    assign wcur = (r_rnd < 7'd16) ? r_w[0] : wnew;
    assign t1 = r_v[7] + (sha256_pkg::ror(r_v[4], 6) ^ sha256_pkg::ror(r_v[4], 11)
              ^ sha256_pkg::ror(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::ROUND_K[r_rnd[5:0]] + wcur;
    assign t2 = (sha256_pkg::ror(r_v[0], 2) ^ sha256_pkg::ror(r_v[0], 13)
              ^ sha256_pkg::ror(r_v[0], 22))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign o_cmd_pop   = (r_st == sha256_pkg::ST_IDLE) && i_cmd_valid;
    assign m_out.valid = r_ovalid;
    assign m_out.data.digest_part = {r_h[{r_part, 1'b0}], r_h[{r_part, 1'b1}]};
    assign m_out.data.part_index  = r_part;
    assign m_out.data.last_part   = (r_part == 2'd3);

    always_comb begin
        n_st = r_st;
        case (r_st)
            sha256_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.has_byte && pos == 6'd63) n_st = sha256_pkg::ST_ROUND;
                    else if (i_cmd.is_last) n_st = sha256_pkg::ST_PAD;
                end
            end
            sha256_pkg::ST_ROUND:
                if (r_rnd == sha256_pkg::NUM_ROUNDS - 7'd1) n_st = sha256_pkg::ST_ADD;
            sha256_pkg::ST_ADD: begin
                if (r_two) n_st = sha256_pkg::ST_ROUND;
                else if (r_fin) n_st = sha256_pkg::ST_EMIT;
                else if (r_lastcmd) n_st = sha256_pkg::ST_PAD;
                else n_st = sha256_pkg::ST_IDLE;
            end
            sha256_pkg::ST_PAD:  n_st = sha256_pkg::ST_ROUND;
            sha256_pkg::ST_EMIT:
                if (m_out.ready && r_part == 2'd3) n_st = sha256_pkg::ST_IDLE;
            default: n_st = sha256_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= sha256_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (r_st == sha256_pkg::ST_IDLE && i_cmd_valid) begin
            r_lastcmd <= i_cmd.is_last;
            if (i_cmd.has_byte) begin
                if (pos[1:0] == 2'd0) r_blk[wi] <= {i_cmd.data_byte, 24'd0};
                else r_blk[wi] <= r_blk[wi] | ({24'd0, i_cmd.data_byte} << bsh);
                if (pos == 6'd63) begin
                    for (int i = 0; i < 15; i++) r_w[i] <= r_blk[i];
                    r_w[15] <= {r_blk[15][31:8], i_cmd.data_byte};
                end
            end
        end
        if (r_st == sha256_pkg::ST_PAD) begin
            for (int i = 0; i < 16; i++) begin
                if (i < wi) r_w[i] <= r_blk[i];
                else if (i > wi) r_w[i] <= 32'd0;
                else if (pos[1:0] == 2'd0) r_w[i] <= {sha256_pkg::PAD_BYTE, 24'd0};
                else r_w[i] <= r_blk[i] | ({24'd0, sha256_pkg::PAD_BYTE} << bsh);
            end
            if (pos < sha256_pkg::LEN_POS) begin
                r_w[14] <= r_cnt[60:29];
                r_w[15] <= {r_cnt[28:0], 3'd0};
            end
        end
        if (r_st == sha256_pkg::ST_ADD && r_two) begin
            for (int i = 0; i < 14; i++) r_w[i] <= 32'd0;
            r_w[14] <= r_cnt[60:29];
            r_w[15] <= {r_cnt[28:0], 3'd0};
        end
        if (r_st == sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wcur;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        // back-to-back compression starts from the chain being added this cycle
        if (n_st == sha256_pkg::ST_ROUND && r_st != sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < 8; i++) begin
                if (r_st == sha256_pkg::ST_ADD) r_v[i] <= r_h[i] + r_v[i];
                else r_v[i] <= r_h[i];
            end
        end
    end

    assign ld_fin = (r_st == sha256_pkg::ST_PAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::INIT_H[i];
            r_cnt <= 64'd0; r_rnd <= 7'd0; r_fin <= 1'b0; r_two <= 1'b0;
            r_part <= 2'd0; r_ovalid <= 1'b0;
        end else begin
            if (r_st == sha256_pkg::ST_IDLE && i_cmd_valid && i_cmd.has_byte)
                r_cnt <= r_cnt + 64'd1;
            if (r_st == sha256_pkg::ST_ROUND) r_rnd <= r_rnd + 7'd1;
            else r_rnd <= 7'd0;
            if (ld_fin) begin
                r_fin <= 1'b1;
                r_two <= (pos >= sha256_pkg::LEN_POS);
            end
            if (r_st == sha256_pkg::ST_ADD) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_two <= 1'b0;
                if (!r_two && r_fin) r_ovalid <= 1'b1;
            end
            if (r_st == sha256_pkg::ST_EMIT && m_out.ready) begin
                r_part <= r_part + 2'd1;
                if (r_part == 2'd3) begin
                    r_ovalid <= 1'b0;
                    r_fin    <= 1'b0;
                    r_cnt    <= 64'd0;
                    for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::INIT_H[i];
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == sha256_pkg::ST_EMIT) |-> r_ovalid) else $error("emit without valid");
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= sha256_pkg::NUM_ROUNDS) else $error("round overrun");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> !r_ovalid) else $error("pop during emit");
`endif
endmodule

FILE: rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// One message byte per input request, 256-bit digest out as four requests.
// ----------------------------------------------------------------------------
// Input channel: data_byte, is_last, message_empty; an item is taken when
// valid and ready are both high. A two-entry command queue sits between the
// front end and the compression engine so input is still taken while the
// engine works, until the queue is full.
// Throughput: each ordinary byte is absorbed while the engine is idle; every
// 64th byte starts a compression (64 rounds plus the chaining add, one round
// per cycle through the shared round unit). A last item adds a padding step
// and one or two compressions, then four output requests.
// Output channel: digest_part, part_index, last_part; part 0 is most
// significant. When the receiver stalls the current part holds and the
// engine waits; the input queue fills and then drops ready.
// Reset loads the initial vector and clears the byte count and queue.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
    input  logic i_clk,
    input  logic i_rst_n,
    sha256_if.sink   s_in,
    sha256_if.source m_out
);
    logic             cmd_valid, cmd_pop;
    sha256_pkg::t_cmd cmd;

    sha256_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_pop(cmd_pop)
    );

    sha256_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_pop(cmd_pop), .m_out(m_out)
    );
endmodule

FILE: tb/sv/sha256_message_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Drives byte requests with random gaps, predicts each message digest with
// an independent SHA-256 model and checks all four output parts in order.
// ----------------------------------------------------------------------------
module sha256_message_hasher_tb;

    localparam int MAX_CYCLES = 400000;

    logic i_clk;
    logic i_rst_n;
    logic errors;
    int   cycle_cnt;
    bit   quiet_phase;
    bit   hold_off;

    sha256_if #(.T(sha256_pkg::t_in_req))  in_ch ();
    sha256_if #(.T(sha256_pkg::t_out_req)) out_ch ();

    sha256_message_hasher dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .s_in   (in_ch.sink),
        .m_out  (out_ch.source)
    );

    // Digest predictor state
    logic [31:0] hash_h [8];
    logic [31:0] msg_blk [16];
    logic [63:0] msg_bytes;
    sha256_pkg::t_out_req digest_q [$];

    // Directed stimulus rows
    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       empty;
    } t_row;
    t_row dir_rows [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w[r] = msg_blk[r];
            end else begin
                w[r] = w[r-16] + (rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3))
                     + w[r-7] + (rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10));
            end
        end
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int r = 0; r < 64; r++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + sha256_pkg::ROUND_K[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    task automatic place_byte(input int pos, input logic [7:0] v);
        if (pos[1:0] == 2'd0) msg_blk[pos >> 2] = '0;
        msg_blk[pos >> 2] |= 32'(v) << ((3 - pos[1:0]) * 8);
    endtask

    task automatic predict_digest(input sha256_pkg::t_in_req rq);
        int       pos;
        logic [63:0] bits;
        sha256_pkg::t_out_req part;
        if (!rq.message_empty) begin
            pos = int'(msg_bytes[5:0]);
            place_byte(pos, rq.data_byte);
            msg_bytes++;
            if (pos == 63) compress();
        end
        if (!rq.is_last) return;
        pos = int'(msg_bytes[5:0]);
        place_byte(pos, sha256_pkg::PAD_BYTE);
        for (int i = (pos >> 2) + 1; i < 16; i++) msg_blk[i] = '0;
        if (pos >= 56) begin
            compress();
            foreach (msg_blk[i]) msg_blk[i] = '0;
        end
        bits = msg_bytes << 3;
        msg_blk[14] = bits[63:32];
        msg_blk[15] = bits[31:0];
        compress();
        for (int i = 0; i < 4; i++) begin
            part.digest_part = {hash_h[2*i], hash_h[2*i+1]};
            part.part_index  = 2'(i);
            part.last_part   = (i == 3);
            digest_q.push_back(part);
        end
        foreach (hash_h[i]) hash_h[i] = sha256_pkg::INIT_H[i];
        msg_bytes = '0;
    endtask

    // Sender: one request, with random idle bursts before it
    task automatic send_req(input logic [7:0] b, input logic last, input logic empty);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{data_byte: b, is_last: last, message_empty: empty};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_digest(in_ch.data);
    endtask

    task automatic send_message(input int len, input bit use_empty_end);
        for (int i = 0; i < len; i++) begin
            if (!use_empty_end && i == len - 1)
                send_req(8'($urandom), 1'b1, 1'b0);
            else
                send_req(8'($urandom), 1'b0, 1'b0);
            // occasional ignored filler
            if ($urandom_range(0, 40) == 0) send_req(8'($urandom), 1'b0, 1'b1);
        end
        if (use_empty_end) send_req(8'($urandom), 1'b1, 1'b1);
    endtask

    function automatic int pick_len();
        case ($urandom_range(0, 5))
            0: return $urandom_range(54, 58);
            1: return $urandom_range(118, 122);
            2: return $urandom_range(62, 66);
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    // Receiver: random stall bursts, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off || (!quiet_phase && $urandom_range(0, 4) == 0)) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (i_rst_n);
        repeat (400) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (600) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Result checker
    always @(posedge i_clk) begin
        sha256_pkg::t_out_req exp_part;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest part %h", out_ch.data.digest_part);
                errors = 1'b1;
            end else begin
                exp_part = digest_q.pop_front();
                if (out_ch.data.digest_part !== exp_part.digest_part) begin
                    $error("digest_part exp %h got %h", exp_part.digest_part,
                           out_ch.data.digest_part);
                    errors = 1'b1;
                end
                if (out_ch.data.part_index !== exp_part.part_index) begin
                    $error("part_index exp %0d got %0d", exp_part.part_index,
                           out_ch.data.part_index);
                    errors = 1'b1;
                end
                if (out_ch.data.last_part !== exp_part.last_part) begin
                    $error("last_part exp %0d got %0d", exp_part.last_part,
                           out_ch.data.last_part);
                    errors = 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int sent;
        int len;
        errors      = 1'b0;
        cycle_cnt   = 0;
        quiet_phase = 1'b0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        foreach (hash_h[i]) hash_h[i] = sha256_pkg::INIT_H[i];
        foreach (msg_blk[i]) msg_blk[i] = '0;
        msg_bytes = '0;

        // empty message, "abc", extreme bytes, ignored filler
        dir_rows.push_back('{8'hff, 1'b1, 1'b1});
        dir_rows.push_back('{8'h61, 1'b0, 1'b0});
        dir_rows.push_back('{8'h62, 1'b0, 1'b0});
        dir_rows.push_back('{8'h00, 1'b0, 1'b1});
        dir_rows.push_back('{8'h63, 1'b1, 1'b0});
        dir_rows.push_back('{8'h00, 1'b1, 1'b0});
        dir_rows.push_back('{8'hff, 1'b1, 1'b0});
        dir_rows.push_back('{8'hff, 1'b0, 1'b0});
        dir_rows.push_back('{8'h55, 1'b0, 1'b0});
        dir_rows.push_back('{8'haa, 1'b0, 1'b1});
        dir_rows.push_back('{8'h00, 1'b1, 1'b1});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].b, dir_rows[i].last, dir_rows[i].empty);
            // Known digests: empty string and "abc"
            if (i == 0 && digest_q[digest_q.size() - 4].digest_part !==
                    64'he3b0c44298fc1c14) begin
                $error("digest_part exp %h got %h", 64'he3b0c44298fc1c14,
                       digest_q[digest_q.size() - 4].digest_part);
                errors = 1'b1;
            end
            if (i == 4 && digest_q[digest_q.size() - 4].digest_part !==
                    64'hba7816bf8f01cfea) begin
                $error("digest_part exp %h got %h", 64'hba7816bf8f01cfea,
                       digest_q[digest_q.size() - 4].digest_part);
                errors = 1'b1;
            end
        end

        sent = 0;
        while (sent < 480) begin
            if (sent > 400) quiet_phase = 1'b1;
            len = pick_len();
            if (len > 480 - sent) len = 480 - sent;
            send_message(len, $urandom_range(0, 4) == 0);
            sent += len;
        end
        in_ch.valid <= 1'b0;

        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!errors)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
